/* rtl/rasi_pkg.sv */
// Shared widths, command codes and controller/datapath handshake types for the ray-segment block.
package rasi_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int LIM_BITS   = COORD_BITS - 1;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * COORD_BITS;
  localparam int GATE_BITS  = LIM_BITS + COORD_BITS;
  localparam int QUO_BITS   = COORD_BITS + 3;
  localparam int HIGH_BITS  = PROD_BITS - QUO_BITS;
  localparam int CNT_BITS   = $clog2(QUO_BITS + 1);
  localparam int CMD_BITS   = 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [LIM_BITS-1:0]          lim_t;
  typedef logic [CMD_BITS-1:0]          cmd_t;

  localparam cmd_t CMD_LOAD = 2'd0;
  localparam cmd_t CMD_HORZ = 2'd1;
  localparam cmd_t CMD_VERT = 2'd2;

  localparam lim_t   LIMIT_MAX = {LIM_BITS{1'b1}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic capture;
    logic load;
    logic sub;
    logic mag;
    logic mul;
    logic div_start;
    logic sat;
    logic cmp;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic gate_ok;
    logic div_done;
  } ctl_sts_t;

endpackage

/* rtl/rasi_in_if.sv */
// Input channel carrying one command item with valid/ready handshake.
interface rasi_in_if;
  import rasi_pkg::*;

  logic   valid;
  logic   ready;
  cmd_t   command;
  coord_t ray_origin_x;
  coord_t ray_origin_y;
  coord_t ray_dir_x;
  coord_t ray_dir_y;
  lim_t   ray_limit;
  logic   ray_unbounded;
  coord_t seg_start;
  coord_t seg_end;
  coord_t seg_fixed;

  modport source (
    output valid, command, ray_origin_x, ray_origin_y, ray_dir_x, ray_dir_y,
    output ray_limit, ray_unbounded, seg_start, seg_end, seg_fixed,
    input  ready
  );

  modport sink (
    input  valid, command, ray_origin_x, ray_origin_y, ray_dir_x, ray_dir_y,
    input  ray_limit, ray_unbounded, seg_start, seg_end, seg_fixed,
    output ready
  );
endinterface

/* rtl/rasi_out_if.sv */
// Result channel carrying the hit flag and current ray limit with valid/ready handshake.
interface rasi_out_if;
  import rasi_pkg::*;

  logic valid;
  logic ready;
  logic hit;
  lim_t current_limit;
  logic current_unbounded;

  modport source (
    output valid, hit, current_limit, current_unbounded,
    input  ready
  );

  modport sink (
    input  valid, hit, current_limit, current_unbounded,
    output ready
  );
endinterface

/* rtl/ray_axis_segment_intersect.sv */
// Top level: ray versus axis-aligned segment intersection in signed Q16.16.
//
//   Channel   Direction  Handshake            Content
//   in_chan   input      valid/ready          command, ray fields, segment fields
//   out_chan  output     valid/ready          hit, current_limit, current_unbounded
//   cfg       input      cfg_we, no wait      half_thickness
//
// One item is in flight at a time; a load or unused command goes straight to finish.
// A segment test runs through the 35-step radix-2 dividers, or goes to finish early
// when the gate rejects the ray.
// A finished result waits in the output register while the next item is taken;
// the next result is held back until that transfer happens.
// Reset is synchronous and active low; it restores the default ray and clears
// half_thickness.
module ray_axis_segment_intersect (
  input  logic           clk,
  input  logic           rst_n,
  rasi_in_if.sink        in_chan,
  rasi_out_if.source     out_chan,
  input  logic           cfg_we,
  input  rasi_pkg::lim_t cfg_wdata
);
  import rasi_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  rasi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_command (in_chan.command),
    .in_ready   (in_chan.ready),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  rasi_dpath u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_command            (in_chan.command),
    .in_ray_origin_x       (in_chan.ray_origin_x),
    .in_ray_origin_y       (in_chan.ray_origin_y),
    .in_ray_dir_x          (in_chan.ray_dir_x),
    .in_ray_dir_y          (in_chan.ray_dir_y),
    .in_ray_limit          (in_chan.ray_limit),
    .in_ray_unbounded      (in_chan.ray_unbounded),
    .in_seg_start          (in_chan.seg_start),
    .in_seg_end            (in_chan.seg_end),
    .in_seg_fixed          (in_chan.seg_fixed),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .out_hit               (out_chan.hit),
    .out_current_limit     (out_chan.current_limit),
    .out_current_unbounded (out_chan.current_unbounded)
  );
endmodule

/* rtl/rasi_div.sv */
// Radix-2 restoring divider with a bounded quotient width and an overflow flag.
module rasi_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [rasi_pkg::PROD_BITS-1:0]  dividend,
  input  logic [rasi_pkg::COORD_BITS-1:0] divisor,
  output logic                           done,
  output logic [rasi_pkg::QUO_BITS-1:0]   quotient,
  output logic                           ovf
);
  import rasi_pkg::*;

  logic [COORD_BITS-1:0] rem_r, rem_nxt;
  logic [QUO_BITS-1:0]   shf_r, shf_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                  done_r, done_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [COORD_BITS:0]   trial;
  logic [COORD_BITS:0]   diff;
  logic                  ge;
  logic [COORD_BITS-1:0] high_part;

  assign high_part = {{(COORD_BITS-HIGH_BITS){1'b0}}, dividend[PROD_BITS-1:QUO_BITS]};
  assign trial     = {rem_r, shf_r[QUO_BITS-1]};
  assign diff      = trial - {1'b0, divisor};
  assign ge        = trial >= {1'b0, divisor};

  always_comb begin
    rem_nxt  = rem_r;
    shf_nxt  = shf_r;
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    done_nxt = 1'b0;
    if (start) begin
      // Quotient bits above the kept width only matter as saturation.
      rem_nxt = high_part;
      shf_nxt = dividend[QUO_BITS-1:0];
      ovf_nxt = high_part >= divisor;
      cnt_nxt = CNT_BITS'(QUO_BITS);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
      shf_nxt  = {shf_r[QUO_BITS-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = cnt_r == CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    shf_r <= shf_nxt;
    ovf_r <= ovf_nxt;
  end

  assign done     = done_r;
  assign quotient = shf_r;
  assign ovf      = ovf_r;
endmodule

/* rtl/rasi_dpath.sv */
// Datapath: stored ray, segment arithmetic, two dividers and the result register.
module rasi_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  rasi_pkg::ctl_cmd_t cmd,
  output rasi_pkg::ctl_sts_t sts,
  input  rasi_pkg::cmd_t    in_command,
  input  rasi_pkg::coord_t  in_ray_origin_x,
  input  rasi_pkg::coord_t  in_ray_origin_y,
  input  rasi_pkg::coord_t  in_ray_dir_x,
  input  rasi_pkg::coord_t  in_ray_dir_y,
  input  rasi_pkg::lim_t    in_ray_limit,
  input  logic              in_ray_unbounded,
  input  rasi_pkg::coord_t  in_seg_start,
  input  rasi_pkg::coord_t  in_seg_end,
  input  rasi_pkg::coord_t  in_seg_fixed,
  input  logic              cfg_we,
  input  rasi_pkg::lim_t    cfg_wdata,
  output logic              out_hit,
  output rasi_pkg::lim_t    out_current_limit,
  output logic              out_current_unbounded
);
  import rasi_pkg::*;

  // Architectural state.
  lim_t   h_r;
  coord_t org_x_r, org_y_r, dir_x_r, dir_y_r;
  lim_t   lim_r, lim_nxt;
  logic   unb_r, unb_nxt;
  logic   hit_r, hit_nxt;

  // Captured item.
  logic   vert_r;
  coord_t seg_start_r, seg_end_r, seg_fixed_r;

  // Difference stage.
  logic signed [DIFF_BITS-1:0] fp_r, fp_nxt, fa_r, fa_nxt, len_r, len_nxt;
  coord_t dp_r, dp_nxt, da_r, da_nxt;
  coord_t org_p, org_a;

  // Magnitude stage.
  logic [DIFF_BITS-1:0]  fp_abs;
  logic [COORD_BITS-1:0] fp_mag_r, dp_mag_r, da_mag_r;
  logic [COORD_BITS-1:0] dp_mag_nxt, da_mag_nxt;
  logic                  fp_neg_r, dp_neg_r, da_neg_r;

  // Product stage.
  logic [GATE_BITS-1:0]      gate_prod_r;
  logic [PROD_BITS-1:0]      seg_prod_r;
  logic signed [DIFF_BITS:0] lenh_r, lenh_nxt;

  // Dividers.
  logic [PROD_BITS-1:0] ray_dividend;
  logic [QUO_BITS-1:0]  ray_q, seg_q;
  logic                 ray_ovf, seg_ovf, ray_done, seg_done;

  // Saturation stage.
  logic                        ray_neg, ray_big, seg_neg, seg_hi, seg_lo;
  logic                        ray_miss_r, ray_miss_nxt;
  lim_t                        ray_val_r, ray_val_nxt;
  logic signed [QUO_BITS:0]    seg_sq;
  logic signed [QUO_BITS+1:0]  seg_v;
  coord_t                      seg_t_r, seg_t_nxt;

  // Compare stage.
  logic signed [DIFF_BITS:0] seg_ext, neg_h;
  logic                      lo_miss, hi_miss, lim_miss;

  // Result register.
  logic out_hit_r, out_unb_r;
  lim_t out_lim_r;

  assign org_p   = vert_r ? org_x_r : org_y_r;
  assign org_a   = vert_r ? org_y_r : org_x_r;
  assign fp_nxt  = {seg_fixed_r[COORD_BITS-1], seg_fixed_r} - {org_p[COORD_BITS-1], org_p};
  assign fa_nxt  = {seg_start_r[COORD_BITS-1], seg_start_r} - {org_a[COORD_BITS-1], org_a};
  assign len_nxt = {seg_end_r[COORD_BITS-1], seg_end_r}
                 - {seg_start_r[COORD_BITS-1], seg_start_r};
  assign dp_nxt  = vert_r ? dir_x_r : dir_y_r;
  assign da_nxt  = vert_r ? dir_y_r : dir_x_r;

  assign fp_abs     = fp_r[DIFF_BITS-1] ? DIFF_BITS'(0) - fp_r : fp_r;
  assign dp_mag_nxt = dp_r[COORD_BITS-1] ? COORD_BITS'(0) - dp_r : dp_r;
  assign da_mag_nxt = da_r[COORD_BITS-1] ? COORD_BITS'(0) - da_r : da_r;

  assign lenh_nxt = {len_r[DIFF_BITS-1], len_r} + {{(DIFF_BITS+1-LIM_BITS){1'b0}}, h_r};

  assign sts.gate_ok  = unb_r ? (dp_mag_r != '0)
                              : (gate_prod_r > GATE_BITS'({h_r, {FRAC_BITS{1'b0}}}));
  assign sts.div_done = ray_done & seg_done;

  assign ray_dividend = {{(PROD_BITS-COORD_BITS-FRAC_BITS){1'b0}}, fp_mag_r, {FRAC_BITS{1'b0}}};

  rasi_div u_ray_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (ray_dividend),
    .divisor  (dp_mag_r),
    .done     (ray_done),
    .quotient (ray_q),
    .ovf      (ray_ovf)
  );

  rasi_div u_seg_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (seg_prod_r),
    .divisor  (dp_mag_r),
    .done     (seg_done),
    .quotient (seg_q),
    .ovf      (seg_ovf)
  );

  // A negative quotient of zero is still zero and so not behind the origin.
  assign ray_neg      = fp_neg_r ^ dp_neg_r;
  assign ray_big      = ray_ovf || (ray_q > QUO_BITS'(LIMIT_MAX));
  assign ray_val_nxt  = ray_big ? LIMIT_MAX : ray_q[LIM_BITS-1:0];
  assign ray_miss_nxt = ray_neg && (ray_ovf || (ray_q != '0));

  assign seg_neg = fp_neg_r ^ da_neg_r ^ dp_neg_r;
  assign seg_sq  = seg_neg ? (QUO_BITS+1)'(0) - {1'b0, seg_q} : {1'b0, seg_q};
  assign seg_v   = {seg_sq[QUO_BITS], seg_sq}
                 - {{(QUO_BITS+2-DIFF_BITS){fa_r[DIFF_BITS-1]}}, fa_r};
  assign seg_hi  = !seg_v[QUO_BITS+1] && (|seg_v[QUO_BITS:COORD_BITS-1]);
  assign seg_lo  = seg_v[QUO_BITS+1] && !(&seg_v[QUO_BITS:COORD_BITS-1]);

  always_comb begin
    if (seg_ovf) begin
      seg_t_nxt = seg_neg ? COORD_MIN : COORD_MAX;
    end else if (seg_hi) begin
      seg_t_nxt = COORD_MAX;
    end else if (seg_lo) begin
      seg_t_nxt = COORD_MIN;
    end else begin
      seg_t_nxt = seg_v[COORD_BITS-1:0];
    end
  end

  assign seg_ext  = {{2{seg_t_r[COORD_BITS-1]}}, seg_t_r};
  assign neg_h    = (DIFF_BITS+1)'(0) - {{(DIFF_BITS+1-LIM_BITS){1'b0}}, h_r};
  assign lo_miss  = seg_ext < neg_h;
  assign hi_miss  = seg_ext > lenh_r;
  assign lim_miss = !unb_r && (ray_val_r > lim_r);

  always_comb begin
    hit_nxt = hit_r;
    lim_nxt = lim_r;
    unb_nxt = unb_r;
    if (cmd.capture) begin
      hit_nxt = 1'b0;
    end
    if (cmd.load) begin
      lim_nxt = in_ray_limit;
      unb_nxt = in_ray_unbounded;
    end
    if (cmd.cmp) begin
      hit_nxt = !ray_miss_r && !lim_miss && !lo_miss && !hi_miss;
      if (!ray_miss_r && !lim_miss && !lo_miss && !hi_miss) begin
        lim_nxt = ray_val_r;
        unb_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r     <= '0;
      org_x_r <= '0;
      org_y_r <= '0;
      dir_x_r <= '0;
      dir_y_r <= '0;
      lim_r   <= '0;
      unb_r   <= 1'b1;
      hit_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        h_r <= cfg_wdata;
      end
      if (cmd.load) begin
        org_x_r <= in_ray_origin_x;
        org_y_r <= in_ray_origin_y;
        dir_x_r <= in_ray_dir_x;
        dir_y_r <= in_ray_dir_y;
      end
      lim_r <= lim_nxt;
      unb_r <= unb_nxt;
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      vert_r      <= in_command == CMD_VERT;
      seg_start_r <= in_seg_start;
      seg_end_r   <= in_seg_end;
      seg_fixed_r <= in_seg_fixed;
    end
    if (cmd.sub) begin
      fp_r  <= fp_nxt;
      fa_r  <= fa_nxt;
      len_r <= len_nxt;
      dp_r  <= dp_nxt;
      da_r  <= da_nxt;
    end
    if (cmd.mag) begin
      fp_mag_r <= fp_abs[COORD_BITS-1:0];
      dp_mag_r <= dp_mag_nxt;
      da_mag_r <= da_mag_nxt;
      fp_neg_r <= fp_r[DIFF_BITS-1];
      dp_neg_r <= dp_r[COORD_BITS-1];
      da_neg_r <= da_r[COORD_BITS-1];
    end
    if (cmd.mul) begin
      gate_prod_r <= GATE_BITS'(lim_r) * GATE_BITS'(dp_mag_r);
      seg_prod_r  <= PROD_BITS'(fp_mag_r) * PROD_BITS'(da_mag_r);
      lenh_r      <= lenh_nxt;
    end
    if (cmd.sat) begin
      ray_miss_r <= ray_miss_nxt;
      ray_val_r  <= ray_val_nxt;
      seg_t_r    <= seg_t_nxt;
    end
    if (cmd.out_load) begin
      out_hit_r <= hit_r;
      out_lim_r <= lim_r;
      out_unb_r <= unb_r;
    end
  end

  assign out_hit               = out_hit_r;
  assign out_current_limit     = out_lim_r;
  assign out_current_unbounded = out_unb_r;
endmodule

/* rtl/rasi_ctrl.sv */
// Controller state machine that sequences the datapath and owns both handshakes.
module rasi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  rasi_pkg::cmd_t    in_command,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output rasi_pkg::ctl_cmd_t cmd,
  input  rasi_pkg::ctl_sts_t sts
);
  import rasi_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SUB  = 4'd1;
  localparam logic [3:0] S_MAG  = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_GATE = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_SAT  = 4'd6;
  localparam logic [3:0] S_CMP  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_xfer;

  assign in_ready = state_r == S_IDLE;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd.capture = 1'b1;
          cmd.load    = in_command == CMD_LOAD;
          case (in_command) inside
            CMD_HORZ, CMD_VERT: state_nxt = S_SUB;
            default:            state_nxt = S_FIN;
          endcase
        end
      end
      S_SUB: begin
        cmd.sub   = 1'b1;
        state_nxt = S_MAG;
      end
      S_MAG: begin
        cmd.mag   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_GATE;
      end
      S_GATE: begin
        if (sts.gate_ok) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_SAT;
        end
      end
      S_SAT: begin
        cmd.sat   = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
endmodule

/* rtl/rasi_checker.sv */
// Port-level checker for the ray-segment block and its bind to the top level.
module rasi_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input logic           out_hit,
  input rasi_pkg::lim_t out_current_limit,
  input logic           out_current_unbounded
);

  // Only one item is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a transfer");

  // A hit always leaves the ray bounded.
  a_hit_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_current_unbounded)
    else $error("hit reported with the ray still unbounded");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && !out_ready |=> out_valid && $stable(out_hit)
      && $stable(out_current_limit) && $stable(out_current_unbounded))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ray_axis_segment_intersect rasi_checker u_rasi_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_chan.valid),
  .in_ready              (in_chan.ready),
  .out_valid             (out_chan.valid),
  .out_ready             (out_chan.ready),
  .out_hit               (out_chan.hit),
  .out_current_limit     (out_chan.current_limit),
  .out_current_unbounded (out_chan.current_unbounded)
);

/* test/ray_axis_segment_intersect_tb.sv */
// Self-checking testbench for the ray versus axis-aligned segment intersection block.
`timescale 1ns / 100ps

module ray_axis_segment_intersect_tb;
  import rasi_pkg::*;

  localparam cmd_t            CMD_UNUSED  = 2'd3;
  localparam longint          UNIT        = 1 << FRAC_BITS;
  localparam longint unsigned QUOT_CAP    = 64'h4000_0000_0000_0000;
  localparam int              PHASE_ITEMS = 250;
  localparam int              IDLE_PAUSE  = 50;
  localparam int              CYCLE_LIMIT = 800000;

  typedef struct {
    cmd_t   command;
    coord_t ray_origin_x;
    coord_t ray_origin_y;
    coord_t ray_dir_x;
    coord_t ray_dir_y;
    lim_t   ray_limit;
    logic   ray_unbounded;
    coord_t seg_start;
    coord_t seg_end;
    coord_t seg_fixed;
  } ray_item_t;

  typedef struct {
    logic hit;
    lim_t current_limit;
    logic current_unbounded;
  } ray_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  lim_t cfg_wdata;

  rasi_in_if  in_if ();
  rasi_out_if out_if ();

  ray_axis_segment_intersect i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  ray_item_t   item_backlog[$];
  ray_result_t predicted_results[$];
  ray_item_t   cur_item;
  int          queued_items = 0;
  int          errors = 0;
  int          cycles = 0;
  int          in_gap = 0;
  int          out_left = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;

  longint ray_ox = 0;
  longint ray_oy = 0;
  longint ray_dx = 0;
  longint ray_dy = 0;
  lim_t   ray_lim = '0;
  logic   ray_unb = 1'b1;
  lim_t   thick = '0;

  function automatic longint unsigned magnitude(input longint v);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    return m;
  endfunction

  function automatic longint clamp_coord(input longint v);
    if (v > longint'(COORD_MAX)) return longint'(COORD_MAX);
    if (v < longint'(COORD_MIN)) return longint'(COORD_MIN);
    return v;
  endfunction

  function automatic longint trunc_quot(input longint unsigned num, input logic num_neg,
                                       input longint unsigned den, input logic den_neg);
    longint unsigned q;
    q = num / den;
    if (q > QUOT_CAP) q = QUOT_CAP;
    return (num_neg != den_neg) ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic cross_segment(input longint fp, input longint fa, input longint dp,
                                         input longint da, input longint span);
    longint unsigned fp_mag, dp_mag, da_mag, gate_lhs, gate_rhs;
    longint reach, lim_v, ray_t, seg_t;
    fp_mag = magnitude(fp);
    dp_mag = magnitude(dp);
    da_mag = magnitude(da);
    reach = thick;
    lim_v = ray_lim;
    if (ray_unb) begin
      if (dp_mag == 0) return 1'b0;
    end else begin
      gate_lhs = ray_lim;
      gate_lhs = gate_lhs * dp_mag;
      gate_rhs = thick;
      gate_rhs = gate_rhs << FRAC_BITS;
      if (gate_lhs <= gate_rhs) return 1'b0;
    end
    ray_t = clamp_coord(trunc_quot(fp_mag << FRAC_BITS, fp < 0, dp_mag, dp < 0));
    if (ray_t < 0) return 1'b0;
    if (!ray_unb && ray_t > lim_v) return 1'b0;
    seg_t = trunc_quot(fp_mag * da_mag, (fp < 0) != (da < 0), dp_mag, dp < 0);
    seg_t = clamp_coord(seg_t - fa);
    if (seg_t < -reach || seg_t > span + reach) return 1'b0;
    ray_lim = ray_t[LIM_BITS-1:0];
    ray_unb = 1'b0;
    return 1'b1;
  endfunction

  function automatic ray_result_t advance_ray(input ray_item_t it);
    ray_result_t r;
    r.hit = 1'b0;
    case (it.command)
      CMD_LOAD: begin
        ray_ox = it.ray_origin_x;
        ray_oy = it.ray_origin_y;
        ray_dx = it.ray_dir_x;
        ray_dy = it.ray_dir_y;
        ray_lim = it.ray_limit;
        ray_unb = it.ray_unbounded;
      end
      CMD_HORZ: begin
        r.hit = cross_segment(longint'(it.seg_fixed) - ray_oy, longint'(it.seg_start) - ray_ox,
                              ray_dy, ray_dx, longint'(it.seg_end) - longint'(it.seg_start));
      end
      CMD_VERT: begin
        r.hit = cross_segment(longint'(it.seg_fixed) - ray_ox, longint'(it.seg_start) - ray_oy,
                              ray_dx, ray_dy, longint'(it.seg_end) - longint'(it.seg_start));
      end
      default: begin
      end
    endcase
    r.current_limit = ray_lim;
    r.current_unbounded = ray_unb;
    return r;
  endfunction

  function automatic longint srand(input int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic longint pick_dir();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return srand(16);
      2: return longint'($signed($urandom()));
      default: return srand(8 << 16);
    endcase
  endfunction

  function automatic ray_item_t noise_item();
    ray_item_t it;
    it.command = cmd_t'($urandom_range(0, 3));
    it.ray_origin_x = $urandom();
    it.ray_origin_y = $urandom();
    it.ray_dir_x = $urandom();
    it.ray_dir_y = $urandom();
    it.ray_limit = lim_t'($urandom());
    it.ray_unbounded = 1'($urandom_range(0, 1));
    it.seg_start = $urandom();
    it.seg_end = $urandom();
    it.seg_fixed = $urandom();
    return it;
  endfunction

  function automatic ray_item_t load_item(input longint ox, input longint oy, input longint dx,
                                          input longint dy, input lim_t lim, input logic unb);
    ray_item_t it;
    it = noise_item();
    it.command = CMD_LOAD;
    it.ray_origin_x = coord_t'(ox);
    it.ray_origin_y = coord_t'(oy);
    it.ray_dir_x = coord_t'(dx);
    it.ray_dir_y = coord_t'(dy);
    it.ray_limit = lim;
    it.ray_unbounded = unb;
    return it;
  endfunction

  function automatic ray_item_t seg_item(input cmd_t cmd, input longint s, input longint e,
                                         input longint f);
    ray_item_t it;
    it = noise_item();
    it.command = cmd;
    it.seg_start = coord_t'(s);
    it.seg_end = coord_t'(e);
    it.seg_fixed = coord_t'(f);
    return it;
  endfunction

  task automatic queue_item(input ray_item_t it);
    item_backlog.push_back(it);
    if (it.command != CMD_UNUSED) queued_items++;
  endtask

  // A ray followed by segments placed around points along it, so that most tests get deep.
  task automatic add_scene();
    ray_item_t it;
    longint ox, oy, dx, dy, t, px, py, along, fixed, s, e, tmp;
    int n;
    ox = srand(200 << 16);
    oy = srand(200 << 16);
    dx = pick_dir();
    dy = pick_dir();
    it = load_item(ox, oy, dx, dy, ($urandom_range(0, 4) == 0) ? lim_t'($urandom()) :
                   lim_t'($urandom_range(0, 100 << 16)), 1'($urandom_range(0, 1)));
    queue_item(it);
    n = $urandom_range(2, 10);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) t = -longint'($urandom_range(0, 8 << 16));
      else t = longint'($urandom_range(0, 60 << 16));
      px = ox + ((dx * t) >>> FRAC_BITS);
      py = oy + ((dy * t) >>> FRAC_BITS);
      it = noise_item();
      it.command = $urandom_range(0, 1) ? CMD_HORZ : CMD_VERT;
      if ($urandom_range(0, 15) == 0) it.command = CMD_UNUSED;
      fixed = (it.command == CMD_HORZ) ? py : px;
      along = (it.command == CMD_HORZ) ? px : py;
      if ($urandom_range(0, 3) == 0) fixed = fixed + srand(2 << 16);
      s = along - longint'($urandom_range(0, 20 << 16));
      e = along + longint'($urandom_range(0, 20 << 16));
      if ($urandom_range(0, 5) == 0) begin
        tmp = srand(30 << 16);
        s = s + tmp;
        e = e + tmp;
      end
      if ($urandom_range(0, 15) == 0) begin
        tmp = s;
        s = e;
        e = tmp;
      end
      it.seg_start = coord_t'(s);
      it.seg_end = coord_t'(e);
      it.seg_fixed = coord_t'(fixed);
      queue_item(it);
    end
  endtask

  task automatic wait_idle();
    while (item_backlog.size() != 0 || predicted_results.size() != 0 || in_if.valid)
      @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  task automatic set_thickness(input lim_t v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    thick = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(negedge clk) begin : drive_items
    if (rst_n && (!in_if.valid || in_fire)) begin
      if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_if.valid <= 1'b0;
      end else if (item_backlog.size() != 0) begin
        cur_item = item_backlog.pop_front();
        in_if.valid <= 1'b1;
        in_if.command <= cur_item.command;
        in_if.ray_origin_x <= cur_item.ray_origin_x;
        in_if.ray_origin_y <= cur_item.ray_origin_y;
        in_if.ray_dir_x <= cur_item.ray_dir_x;
        in_if.ray_dir_y <= cur_item.ray_dir_y;
        in_if.ray_limit <= cur_item.ray_limit;
        in_if.ray_unbounded <= cur_item.ray_unbounded;
        in_if.seg_start <= cur_item.seg_start;
        in_if.seg_end <= cur_item.seg_end;
        in_if.seg_fixed <= cur_item.seg_fixed;
        if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
        in_gap <= in_calm ? 0 : $urandom_range(0, 12);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drive_ready
    int hold;
    if (rst_n) begin
      hold = out_left;
      if (out_fire) begin
        if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
        hold = out_calm ? 0 : $urandom_range(0, 12);
      end
      if (hold != 0) begin
        out_if.ready <= 1'b0;
        out_left <= hold - 1;
      end else begin
        out_if.ready <= 1'b1;
        out_left <= 0;
      end
    end
  end

  always @(posedge clk) begin : watch_transfers
    ray_result_t want;
    in_fire <= rst_n && in_if.valid && in_if.ready;
    out_fire <= rst_n && out_if.valid && out_if.ready;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (predicted_results.size() == 0) begin
        $display("%0t: unexpected result hit %0b limit %0h unbounded %0b", $time,
                 out_if.hit, out_if.current_limit, out_if.current_unbounded);
        errors++;
      end else begin
        want = predicted_results.pop_front();
        if (out_if.hit !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, out_if.hit);
          errors++;
        end
        if (out_if.current_limit !== want.current_limit) begin
          $display("%0t: current_limit expected %0h actual %0h", $time,
                   want.current_limit, out_if.current_limit);
          errors++;
        end
        if (out_if.current_unbounded !== want.current_unbounded) begin
          $display("%0t: current_unbounded expected %0b actual %0b", $time,
                   want.current_unbounded, out_if.current_unbounded);
          errors++;
        end
      end
    end
    if (rst_n && in_if.valid && in_if.ready) predicted_results.push_back(advance_ray(cur_item));
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    lim_t thick_plan[7];
    in_if.valid = 1'b0;
    in_if.command = CMD_LOAD;
    in_if.ray_origin_x = '0;
    in_if.ray_origin_y = '0;
    in_if.ray_dir_x = '0;
    in_if.ray_dir_y = '0;
    in_if.ray_limit = '0;
    in_if.ray_unbounded = 1'b0;
    in_if.seg_start = '0;
    in_if.seg_end = '0;
    in_if.seg_fixed = '0;
    out_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset ray has no direction, so the first test is a parallel miss.
    queue_item(seg_item(CMD_HORZ, 0, 10 * UNIT, 5 * UNIT));
    queue_item(seg_item(CMD_UNUSED, 0, UNIT, UNIT));
    queue_item(load_item(0, 0, UNIT, UNIT, '0, 1'b1));
    queue_item(seg_item(CMD_HORZ, 5 * UNIT, 15 * UNIT, 10 * UNIT));
    queue_item(seg_item(CMD_VERT, 0, 10 * UNIT, 5 * UNIT));
    queue_item(seg_item(CMD_HORZ, 15 * UNIT, 25 * UNIT, 20 * UNIT));
    queue_item(seg_item(CMD_HORZ, -5 * UNIT, 5 * UNIT, -3 * UNIT));
    queue_item(seg_item(CMD_HORZ, UNIT, UNIT, UNIT));
    queue_item(seg_item(CMD_HORZ, 4 * UNIT, 0, UNIT / 2));
    queue_item(load_item(0, 0, 0, UNIT, '0, 1'b0));
    queue_item(seg_item(CMD_HORZ, -UNIT, UNIT, 3 * UNIT));
    queue_item(seg_item(CMD_VERT, -UNIT, UNIT, 3 * UNIT));
    queue_item(load_item(0, 0, 1, 0, '0, 1'b1));
    queue_item(seg_item(CMD_VERT, 0, 10 * UNIT, longint'(COORD_MAX)));
    queue_item(load_item(longint'(COORD_MIN), longint'(COORD_MAX), longint'(COORD_MAX),
                         longint'(COORD_MIN), LIMIT_MAX, 1'b0));
    queue_item(seg_item(CMD_HORZ, longint'(COORD_MIN), longint'(COORD_MAX),
                        longint'(COORD_MIN)));
    queue_item(seg_item(CMD_VERT, longint'(COORD_MAX), longint'(COORD_MIN),
                        longint'(COORD_MAX)));
    queue_item(load_item(longint'(COORD_MAX), longint'(COORD_MIN), longint'(COORD_MIN),
                         longint'(COORD_MAX), LIMIT_MAX, 1'b1));
    queue_item(seg_item(CMD_VERT, longint'(COORD_MIN), longint'(COORD_MAX),
                        longint'(COORD_MIN)));
    queue_item(seg_item(CMD_HORZ, longint'(COORD_MIN), longint'(COORD_MAX),
                        longint'(COORD_MAX)));
    wait_idle();

    // With thickness the segment ends reach further and the bounded gate tightens.
    set_thickness(lim_t'(2 * UNIT));
    queue_item(load_item(0, 0, UNIT, UNIT, lim_t'(100 * UNIT), 1'b0));
    queue_item(seg_item(CMD_HORZ, 11 * UNIT, 20 * UNIT, 10 * UNIT));
    queue_item(seg_item(CMD_VERT, -3 * UNIT, 3 * UNIT, 5 * UNIT));
    queue_item(load_item(0, 0, UNIT, UNIT, lim_t'(1), 1'b0));
    queue_item(seg_item(CMD_HORZ, 0, 10 * UNIT, 5 * UNIT));

    thick_plan[0] = LIMIT_MAX;
    thick_plan[1] = '0;
    thick_plan[2] = lim_t'(1);
    thick_plan[3] = lim_t'(UNIT / 2);
    thick_plan[4] = lim_t'($urandom_range(0, 4 << 16));
    thick_plan[5] = lim_t'($urandom());
    thick_plan[6] = lim_t'(UNIT);
    foreach (thick_plan[p]) begin : phase
      int target;
      wait_idle();
      set_thickness(thick_plan[p]);
      target = queued_items + PHASE_ITEMS;
      while (queued_items < target) begin
        if ($urandom_range(0, 4) == 0) queue_item(noise_item());
        else add_scene();
      end
    end

    wait_idle();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
